>>> rtl/sfr_pkg.sv
package sfr_pkg;

  // Longest frame that is accepted, in bytes, including header and checksum.
  localparam logic [8:0] MAX_FRAME = 9'd64;

  // Fixed frame overhead: start, model, length and checksum bytes.
  localparam logic [8:0] FRAME_OVERHEAD = 9'd4;

  // Reset value of the timeout register.
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // Input command codes.
  localparam logic [1:0] CMD_ARM  = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_MODEL_BYTE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_MS = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_PROGRESS  = 3'd0,
    ST_OK        = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_MODEL = 3'd3,
    ST_BAD_SUM   = 3'd4,
    ST_TIMEOUT   = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_t;

  // Frame tracking state carried from one transaction to the next.
  typedef struct packed {
    phase_t      phase;
    logic [8:0]  byte_count;
    logic [8:0]  frame_total;
    logic [7:0]  lrc_sum;
    logic [15:0] elapsed_ms;
    logic        start_ok;
    logic        model_ok;
  } frame_state_t;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  model_byte;
    logic [15:0] timeout_ms;
  } frame_cfg_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic [8:0] byte_pos;
    logic       last;
    status_t    status;
  } frame_result_t;

endpackage

>>> rtl/sfr_step.sv
module sfr_step (
  input  sfr_pkg::frame_state_t  cur,
  input  sfr_pkg::frame_cfg_t    cfg,
  input  logic [1:0]             cmd,
  input  logic [7:0]             rx_byte,
  output sfr_pkg::frame_state_t  nxt,
  output logic                   res_valid,
  output sfr_pkg::frame_result_t res
);

  logic [9:0] pos_plus_one;
  logic [9:0] total_ext;
  logic [8:0] total_new;
  logic [7:0] sum_new;
  logic [7:0] lrc_expect;
  logic [15:0] elapsed_new;

  // Shared arithmetic for the byte and tick paths.
  assign pos_plus_one = {1'b0, cur.byte_count} + 10'd1;
  assign total_ext    = {1'b0, cur.frame_total};
  assign total_new    = {1'b0, rx_byte} + sfr_pkg::FRAME_OVERHEAD;
  assign sum_new      = cur.lrc_sum + rx_byte;
  assign lrc_expect   = 8'd0 - cur.lrc_sum;
  assign elapsed_new  = (cur.elapsed_ms != 16'hFFFF) ? cur.elapsed_ms + 16'd1
                                                      : cur.elapsed_ms;

  // Command decode and frame state update.
  always_comb begin
    nxt            = cur;
    res_valid      = 1'b0;
    res.frame_byte = rx_byte;
    res.byte_pos   = cur.byte_count;
    res.last       = 1'b0;
    res.status     = sfr_pkg::ST_PROGRESS;

    unique case (cmd)
      sfr_pkg::CMD_ARM: begin
        nxt.phase       = sfr_pkg::PH_RECV;
        nxt.byte_count  = '0;
        nxt.frame_total = '0;
        nxt.lrc_sum     = '0;
        nxt.elapsed_ms  = '0;
        nxt.start_ok    = 1'b0;
        nxt.model_ok    = 1'b0;
      end
      sfr_pkg::CMD_TICK: begin
        if (cur.phase == sfr_pkg::PH_RECV) begin
          nxt.elapsed_ms = elapsed_new;
          if (elapsed_new > cfg.timeout_ms) begin
            nxt.phase      = sfr_pkg::PH_DONE;
            res_valid      = 1'b1;
            res.frame_byte = '0;
            res.last       = 1'b1;
            res.status     = sfr_pkg::ST_TIMEOUT;
          end
        end
      end
      sfr_pkg::CMD_BYTE: begin
        if (cur.phase == sfr_pkg::PH_RECV) begin
          res_valid      = 1'b1;
          nxt.byte_count = pos_plus_one[8:0];
          if (cur.byte_count == 9'd0) begin
            // Start byte: checked but not summed.
            nxt.start_ok = (rx_byte == cfg.start_byte);
          end else if (cur.byte_count == 9'd1) begin
            nxt.model_ok = (rx_byte == cfg.model_byte);
            nxt.lrc_sum  = sum_new;
          end else if (cur.byte_count == 9'd2) begin
            // Length byte sets the total frame size.
            nxt.frame_total = total_new;
            nxt.lrc_sum     = sum_new;
            if (total_new > sfr_pkg::MAX_FRAME) begin
              nxt.phase  = sfr_pkg::PH_DONE;
              res.last   = 1'b1;
              res.status = sfr_pkg::ST_TOO_LONG;
            end
          end else if (pos_plus_one < total_ext) begin
            nxt.lrc_sum = sum_new;
          end else begin
            // Checksum byte: the verdict is given in priority order.
            nxt.phase = sfr_pkg::PH_DONE;
            res.last  = 1'b1;
            if (!cur.start_ok) begin
              res.status = sfr_pkg::ST_BAD_START;
            end else if (!cur.model_ok) begin
              res.status = sfr_pkg::ST_BAD_MODEL;
            end else if (rx_byte != lrc_expect) begin
              res.status = sfr_pkg::ST_BAD_SUM;
            end else begin
              res.status = sfr_pkg::ST_OK;
            end
          end
        end
      end
      default: begin
        // Unused command code: no effect.
      end
    endcase
  end

endmodule

>>> rtl/status_frame_receiver_lrc_unit.sv
// Receives one length-prefixed status frame per arm command and checks its
// longitudinal redundancy checksum. Each input transaction is an arm
// command, a received byte or a one-millisecond tick; every byte received
// while armed produces one result transaction echoing the byte, its
// position and a status, and the byte that ends the frame (or a tick past
// the timeout) carries the verdict with last set. The block takes one input
// transaction per clock: the frame state updates in the cycle of acceptance
// and the result appears in the output register on the next cycle. in_ready
// is high whenever the output register is empty or is being emptied in the
// same cycle, so with out_ready held high the rate is one transaction per
// cycle. Configuration writes take effect on the following cycle.
module status_frame_receiver_lrc_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic [8:0] out_byte_pos,
  output logic       out_last,
  output logic [2:0] out_status
);

  sfr_pkg::frame_cfg_t    cfg_r;
  sfr_pkg::frame_state_t  state_r;
  sfr_pkg::frame_state_t  state_nxt;
  sfr_pkg::frame_result_t res_nxt;
  sfr_pkg::frame_result_t res_r;
  logic                   res_valid_nxt;
  logic                   out_valid_r;
  logic                   in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= '0;
      cfg_r.model_byte <= '0;
      cfg_r.timeout_ms <= sfr_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfr_pkg::REG_START_BYTE: cfg_r.start_byte <= cfg_wdata[7:0];
        sfr_pkg::REG_MODEL_BYTE: cfg_r.model_byte <= cfg_wdata[7:0];
        sfr_pkg::REG_TIMEOUT_MS: cfg_r.timeout_ms <= cfg_wdata;
        default: begin
          // Index outside the register list is ignored.
        end
      endcase
    end
  end

  // Per-transaction frame logic.
  sfr_step u_step (
    .cur       (state_r),
    .cfg       (cfg_r),
    .cmd       (in_cmd),
    .rx_byte   (in_rx_byte),
    .nxt       (state_nxt),
    .res_valid (res_valid_nxt),
    .res       (res_nxt)
  );

  // Frame state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= sfr_pkg::PH_IDLE;
      state_r.byte_count  <= '0;
      state_r.frame_total <= '0;
      state_r.lrc_sum     <= '0;
      state_r.elapsed_ms  <= '0;
      state_r.start_ok    <= 1'b0;
      state_r.model_ok    <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register: loaded on acceptance, drained by out_ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid_nxt) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = res_r.frame_byte;
  assign out_byte_pos   = res_r.byte_pos;
  assign out_last       = res_r.last;
  assign out_status     = res_r.status;

endmodule
